FILE: rtl/ldsfw_pkg.sv
// Shared types, codes and a helper function for the LED driver serial frame writer.
`default_nettype none
package ldsfw_pkg;

  // Item kinds on the input channel.
  typedef enum logic [1:0] {
    KIND_CMD   = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_CONT  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  // Chip select codes.
  localparam logic [1:0] CHIP_NONE = 2'b00;
  localparam logic [1:0] CHIP_ONE  = 2'b01;
  localparam logic [1:0] CHIP_TWO  = 2'b10;
  localparam logic [1:0] CHIP_BOTH = 2'b11;

  // Frame ID codes sent first on the wire.
  localparam logic [2:0] ID_CMD   = 3'b100;
  localparam logic [2:0] ID_WRITE = 3'b101;

  // Longest frame and the strobe counts of each frame kind.
  localparam int unsigned FRAME_BITS = 18;
  localparam int unsigned CNT_W      = $clog2(FRAME_BITS + 1);
  localparam logic [CNT_W-1:0] CNT_CMD   = CNT_W'(12);
  localparam logic [CNT_W-1:0] CNT_WRITE = CNT_W'(18);
  localparam logic [CNT_W-1:0] CNT_CONT  = CNT_W'(8);

  // One prepared frame: bits in wire order starting at the top bit.
  typedef struct packed {
    logic [FRAME_BITS-1:0] bits;
    logic [CNT_W-1:0]      count;
    logic [1:0]            chips;
    logic                  ends;
  } frame_t;

  // Reverse a byte so that LSB-first data can be shifted out from the top.
  function automatic logic [7:0] bit_reverse8(input logic [7:0] val);
    logic [7:0] res;
    for (int i = 0; i < 8; i++) begin
      res[i] = val[7-i];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/ldsfw_ifs.sv
// Valid/ready channel interfaces for input items and output strobes.
`default_nettype none
interface ldsfw_in_if
  import ldsfw_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] address;
  logic [7:0] data_byte;
  logic       end_frame;

  modport source (output valid, kind, address, data_byte, end_frame, input ready);
  modport sink   (input valid, kind, address, data_byte, end_frame, output ready);
endinterface

interface ldsfw_out_if
  import ldsfw_pkg::*;
();
  logic       valid;
  logic       ready;
  logic       bit_value;
  logic [1:0] chip_select;
  logic       frame_end;
  logic       last;

  modport source (output valid, bit_value, chip_select, frame_end, last, input ready);
  modport sink   (input valid, bit_value, chip_select, frame_end, last, output ready);
endinterface
`default_nettype wire

FILE: rtl/ldsfw_frame_build.sv
// Input register, frame state and frame assembly for one input item.
`default_nettype none
module ldsfw_frame_build
  import ldsfw_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  ldsfw_in_if.sink    in_ch,
  output frame_t      frm,
  output logic        frm_valid,
  input  wire logic   frm_ready
);

  logic       item_valid_r;
  logic [1:0] kind_r;
  logic [7:0] address_r;
  logic [7:0] data_r;
  logic       end_r;
  logic       frame_open_r, frame_open_nxt;
  logic [1:0] frame_chips_r, frame_chips_nxt;
  logic       drop;
  logic       take;
  logic [1:0] write_chips;

  // An item leaves the input register when it is dropped or the serializer loads it.
  assign take         = item_valid_r && (drop || frm_ready);
  assign in_ch.ready  = !item_valid_r || take;
  assign frm_valid    = item_valid_r && !drop;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      item_valid_r <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) begin
      kind_r    <= in_ch.kind;
      address_r <= in_ch.address;
      data_r    <= in_ch.data_byte;
      end_r     <= in_ch.end_frame;
    end
  end

  assign write_chips = address_r[7] ? CHIP_TWO : CHIP_ONE;

  // Frame assembly and the next frame state.
  always_comb begin
    drop            = 1'b0;
    frm             = '0;
    frame_open_nxt  = frame_open_r;
    frame_chips_nxt = frame_chips_r;
    case (kind_t'(kind_r))
      KIND_CMD: begin
        frm.bits        = {ID_CMD, data_r, 1'b0, 6'b0};
        frm.count       = CNT_CMD;
        frm.chips       = CHIP_BOTH;
        frm.ends        = 1'b1;
        frame_open_nxt  = 1'b0;
        frame_chips_nxt = CHIP_NONE;
      end
      KIND_WRITE: begin
        frm.bits        = {ID_WRITE, address_r[6:0], bit_reverse8(data_r)};
        frm.count       = CNT_WRITE;
        frm.chips       = write_chips;
        frm.ends        = end_r;
        frame_open_nxt  = !end_r;
        frame_chips_nxt = end_r ? CHIP_NONE : write_chips;
      end
      KIND_CONT: begin
        drop      = !frame_open_r;
        frm.bits  = {bit_reverse8(data_r), 10'b0};
        frm.count = CNT_CONT;
        frm.chips = frame_chips_r;
        frm.ends  = end_r;
        if (end_r) begin
          frame_open_nxt  = 1'b0;
          frame_chips_nxt = CHIP_NONE;
        end
      end
      default: begin
        drop = 1'b1;
      end
    endcase
  end

  // Frame state changes only when a frame goes to the serializer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r  <= 1'b0;
      frame_chips_r <= CHIP_NONE;
    end else if (take && !drop) begin
      frame_open_r  <= frame_open_nxt;
      frame_chips_r <= frame_chips_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/ldsfw_serializer.sv
// Shift register that emits one write strobe per output transaction.
`default_nettype none
module ldsfw_serializer
  import ldsfw_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire frame_t  frm,
  input  wire logic    frm_valid,
  output logic         frm_ready,
  ldsfw_out_if.source  out_ch
);

  logic [FRAME_BITS-1:0] shift_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [1:0]            chips_r;
  logic                  ends_r;
  logic                  is_last;
  logic                  out_take;

  assign is_last   = (cnt_r == CNT_W'(1));
  assign out_take  = out_ch.valid && out_ch.ready;
  // A new frame loads when idle or as the final strobe is taken.
  assign frm_ready = (cnt_r == '0) || (out_take && is_last);

  assign out_ch.valid       = (cnt_r != '0);
  assign out_ch.bit_value   = shift_r[FRAME_BITS-1];
  assign out_ch.chip_select = chips_r;
  assign out_ch.last        = is_last;
  assign out_ch.frame_end   = is_last && ends_r;

  // Strobe counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (frm_ready && frm_valid) begin
      cnt_r <= frm.count;
    end else if (out_take) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  // Payload shift register.
  always_ff @(posedge clk) begin
    if (frm_ready && frm_valid) begin
      shift_r <= frm.bits;
      chips_r <= frm.chips;
      ends_r  <= frm.ends;
    end else if (out_take) begin
      shift_r <= {shift_r[FRAME_BITS-2:0], 1'b0};
    end
  end

endmodule
`default_nettype wire

FILE: rtl/led_driver_serial_frame_writer.sv
// Top level of the LED driver serial frame writer: input stage plus strobe serializer.
// Each input item turns into a frame of write strobes, one output transaction per
// cycle while the output is ready: a command gives 12 strobes, a write start 18 and
// a continuation 8, shifted out by the one-bit-per-cycle shift register in the
// serializer, which holds while the output is not ready. The next item is taken into
// the input register while the current frame is still shifting out and loads as its
// last strobe is taken. A continuation with no open frame and the unused kind code
// produce no strobes and leave the input register without waiting for the serializer.
`default_nettype none
module led_driver_serial_frame_writer
  import ldsfw_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  ldsfw_in_if.sink    in_ch,
  ldsfw_out_if.source out_ch
);

  frame_t frm;
  logic   frm_valid;
  logic   frm_ready;

  ldsfw_frame_build u_build (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .frm       (frm),
    .frm_valid (frm_valid),
    .frm_ready (frm_ready)
  );

  ldsfw_serializer u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .frm       (frm),
    .frm_valid (frm_valid),
    .frm_ready (frm_ready),
    .out_ch    (out_ch)
  );

`ifndef SYNTHESIS
  // Every strobe drives at least one chip select.
  a_cs_driven: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.chip_select != CHIP_NONE))
    else $error("strobe without chip select");

  // A frame can only be released on the last strobe of an item.
  a_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.frame_end) |-> out_ch.last)
    else $error("frame released before last strobe");

  // Broadcast command frames always release the selects.
  a_cmd_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.last && (out_ch.chip_select == CHIP_BOTH))
      |-> out_ch.frame_end)
    else $error("command frame left open");

  // Only frames that carry strobes are handed to the serializer.
  a_frame_count: assert property (@(posedge clk) disable iff (!rst_n)
    frm_valid |-> (frm.count != '0))
    else $error("empty frame handed to serializer");
`endif

endmodule
`default_nettype wire
